// ===== src/bae_pkg.sv =====
`default_nettype none
package bae_pkg;

   localparam int unsigned XLEN      = 64;
   localparam int unsigned DIV_DEPTH = 64;
   localparam int unsigned MUL_DEPTH = 3;

   localparam logic [4:0] MODE_MOV   = 5'd0;
   localparam logic [4:0] MODE_ADD   = 5'd1;
   localparam logic [4:0] MODE_SUB   = 5'd2;
   localparam logic [4:0] MODE_MUL   = 5'd3;
   localparam logic [4:0] MODE_OR    = 5'd4;
   localparam logic [4:0] MODE_AND   = 5'd5;
   localparam logic [4:0] MODE_XOR   = 5'd6;
   localparam logic [4:0] MODE_LSH   = 5'd7;
   localparam logic [4:0] MODE_RSH   = 5'd8;
   localparam logic [4:0] MODE_ARSH  = 5'd9;
   localparam logic [4:0] MODE_NEG   = 5'd10;
   localparam logic [4:0] MODE_UMULH = 5'd11;
   localparam logic [4:0] MODE_SMULH = 5'd12;
   localparam logic [4:0] MODE_UDIV  = 5'd13;
   localparam logic [4:0] MODE_UREM  = 5'd14;
   localparam logic [4:0] MODE_SDIV  = 5'd15;
   localparam logic [4:0] MODE_SREM  = 5'd16;
   localparam logic [4:0] MODE_TOLE  = 5'd17;
   localparam logic [4:0] MODE_TOBE  = 5'd18;
   localparam logic [4:0] MODE_HOR   = 5'd19;
   localparam logic [4:0] MODE_JEQ   = 5'd20;
   localparam logic [4:0] MODE_JNE   = 5'd21;
   localparam logic [4:0] MODE_JGT   = 5'd22;
   localparam logic [4:0] MODE_JGE   = 5'd23;
   localparam logic [4:0] MODE_JLT   = 5'd24;
   localparam logic [4:0] MODE_JLE   = 5'd25;
   localparam logic [4:0] MODE_JSGT  = 5'd26;
   localparam logic [4:0] MODE_JSGE  = 5'd27;
   localparam logic [4:0] MODE_JSLT  = 5'd28;
   localparam logic [4:0] MODE_JSLE  = 5'd29;
   localparam logic [4:0] MODE_JSET  = 5'd30;

   localparam logic [1:0] FAULT_NONE   = 2'd0;
   localparam logic [1:0] FAULT_DIVZ   = 2'd1;
   localparam logic [1:0] FAULT_DIVOVF = 2'd2;
   localparam logic [1:0] FAULT_ENDIAN = 2'd3;

   localparam logic [1:0] KIND_PLAIN = 2'd0;
   localparam logic [1:0] KIND_MULLO = 2'd1;
   localparam logic [1:0] KIND_MULHI = 2'd2;
   localparam logic [1:0] KIND_DIV   = 2'd3;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [4:0]  mode;
      logic        narrow;
      logic [63:0] left_value;
      logic [63:0] right_value;
      logic        swap_sub;
      logic        sign_extend_narrow;
   } req_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic        branch_taken;
      logic [1:0]  fault;
   } rsp_type;

   typedef struct packed {
      logic [63:0] res;
      logic        taken;
      logic [1:0]  fault;
      logic [1:0]  kind;
      logic        narrow;
      logic        sx;
      logic        div_rem;
      logic        div_neg;
   } line_type;

   typedef struct packed {
      line_type    line;
      logic [63:0] div_a;
      logic [63:0] div_b;
      logic        mul_sgn;
   } prep_type;

   function automatic logic [63:0] ext32(input logic [31:0] v, input logic sx);
      ext32 = {(sx && v[31]) ? 32'hFFFF_FFFF : 32'h0, v};
   endfunction

endpackage
`default_nettype wire

// ===== src/bpf_alu_branch_execute_unit_core.sv =====
// path: every operation runs through the full side line and then the output register before its rsp_valid strobe
// throughput: one request per cycle; busy is never raised, set by the 64-stage divider pipe
// the multiplier takes three stages and rides alongside the divider
// reset: synchronous, active high; clears all pipeline valid bits, payload is not reset
// the receiver cannot stall; each result shows for exactly one cycle
`default_nettype none
module bpf_alu_branch_execute_unit_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bae_pkg::req_type req_data,
   output logic             rsp_valid,
   output bae_pkg::rsp_type rsp_data
);
   import bae_pkg::*;

   localparam int unsigned LINE_LEN = DIV_DEPTH + 1;

   prep_type    prep;
   line_type    line_ff [0:LINE_LEN-1];
   line_type    line_in [0:LINE_LEN-1];
   logic        vld_ff  [0:LINE_LEN-1];
   logic [63:0] div_a_ff, div_b_ff, mul_a_ff, mul_b_ff;
   logic        mul_sgn_ff;
   logic [63:0] prod_lo, prod_hi, quot, remd, dv, dres;
   line_type    last;
   rsp_type     rsp_in, rsp_ff;
   logic        rsp_valid_ff;

   assign busy = 1'b0;

   bae_decode u_decode (
      .req  (req_data),
      .prep (prep)
   );

   always_ff @(posedge clock) begin
      div_a_ff   <= prep.div_a;
      div_b_ff   <= prep.div_b;
      mul_a_ff   <= req_data.left_value;
      mul_b_ff   <= req_data.right_value;
      mul_sgn_ff <= prep.mul_sgn;
   end

   bae_mul u_mul (
      .clock   (clock),
      .a       (mul_a_ff),
      .b       (mul_b_ff),
      .sgn     (mul_sgn_ff),
      .prod_lo (prod_lo),
      .prod_hi (prod_hi)
   );

   bae_div u_div (
      .clock     (clock),
      .dividend  (div_a_ff),
      .divisor   (div_b_ff),
      .quotient  (quot),
      .remainder (remd)
   );

   // side line, multiplier result merged when it lands
   always_comb begin
      line_in[0] = prep.line;
      for (int i = 1; i < LINE_LEN; i++) begin
         line_in[i] = line_ff[i-1];
         if (i == MUL_DEPTH + 1) begin
            if (line_ff[i-1].kind == KIND_MULLO) begin
               line_in[i].res = line_ff[i-1].narrow
                  ? ext32(prod_lo[31:0], line_ff[i-1].sx) : prod_lo;
            end else if (line_ff[i-1].kind == KIND_MULHI) begin
               line_in[i].res = prod_hi;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LINE_LEN; i++) begin
         line_ff[i] <= line_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_LEN; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start;
         for (int i = 1; i < LINE_LEN; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // divide sign fix and narrowing
   assign last = line_ff[LINE_LEN-1];
   assign dv   = last.div_rem ? remd : quot;
   assign dres = last.div_neg ? (64'd0 - dv) : dv;

   always_comb begin
      rsp_in.result_value = last.res;
      rsp_in.branch_taken = last.taken;
      rsp_in.fault        = last.fault;
      if (last.kind == KIND_DIV) begin
         rsp_in.result_value = last.narrow ? {32'd0, dres[31:0]} : dres;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[LINE_LEN-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== src/bae_decode.sv =====
`default_nettype none
module bae_decode (
   input  bae_pkg::req_type  req,
   output bae_pkg::prep_type prep
);
   import bae_pkg::*;

   logic [31:0] a32, b32, v32;
   logic [63:0] l, r, v64, ca, cb, sa, sb, flip, sla, slb;
   logic        eq, ult, slt, na, nb, sgn, rem;

   assign l   = req.left_value;
   assign r   = req.right_value;
   assign a32 = l[31:0];
   assign b32 = r[31:0];

   always_comb begin
      case (req.mode)
         MODE_MOV:  v32 = b32;
         MODE_ADD:  v32 = a32 + b32;
         MODE_SUB:  v32 = req.swap_sub ? (b32 - a32) : (a32 - b32);
         MODE_OR:   v32 = a32 | b32;
         MODE_AND:  v32 = a32 & b32;
         MODE_XOR:  v32 = a32 ^ b32;
         MODE_LSH:  v32 = a32 << b32[4:0];
         MODE_RSH:  v32 = a32 >> b32[4:0];
         MODE_ARSH: v32 = 32'($signed(a32) >>> b32[4:0]);
         default:   v32 = 32'd0 - a32;
      endcase
      case (req.mode)
         MODE_MOV:  v64 = r;
         MODE_ADD:  v64 = l + r;
         MODE_SUB:  v64 = req.swap_sub ? (r - l) : (l - r);
         MODE_OR:   v64 = l | r;
         MODE_AND:  v64 = l & r;
         MODE_XOR:  v64 = l ^ r;
         MODE_LSH:  v64 = l << r[5:0];
         MODE_RSH:  v64 = l >> r[5:0];
         MODE_ARSH: v64 = 64'($signed(l) >>> r[5:0]);
         default:   v64 = 64'd0 - l;
      endcase
   end

   // compare operands
   assign ca   = req.narrow ? {32'd0, a32} : l;
   assign cb   = req.narrow ? {32'd0, b32} : r;
   assign flip = req.narrow ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
   assign eq   = (ca == cb);
   assign ult  = (ca < cb);
   assign slt  = ((ca ^ flip) < (cb ^ flip));

   // divide operands, made magnitudes for the signed modes
   assign sgn = (req.mode == MODE_SDIV) || (req.mode == MODE_SREM);
   assign rem = (req.mode == MODE_UREM) || (req.mode == MODE_SREM);
   assign sla = req.narrow ? ext32(a32, 1'b1) : l;
   assign slb = req.narrow ? ext32(b32, 1'b1) : r;
   assign na  = sgn && sla[63];
   assign nb  = sgn && slb[63];
   assign sa  = sgn ? (na ? 64'd0 - sla : sla) : ca;
   assign sb  = sgn ? (nb ? 64'd0 - slb : slb) : cb;

   always_comb begin
      prep.line.res     = l;
      prep.line.taken   = 1'b0;
      prep.line.fault   = FAULT_NONE;
      prep.line.kind    = KIND_PLAIN;
      prep.line.narrow  = req.narrow;
      prep.line.sx      = req.sign_extend_narrow;
      prep.line.div_rem = rem;
      prep.line.div_neg = rem ? na : (na ^ nb);
      prep.div_a        = sa;
      prep.div_b        = sb;
      prep.mul_sgn      = (req.mode == MODE_SMULH);
      case (req.mode) inside
         MODE_MUL:
            prep.line.kind = KIND_MULLO;
         MODE_MOV, [MODE_ADD:MODE_SUB], [MODE_OR:MODE_NEG]:
            prep.line.res = req.narrow ? ext32(v32, req.sign_extend_narrow) : v64;
         MODE_UMULH, MODE_SMULH:
            prep.line.kind = KIND_MULHI;
         [MODE_UDIV:MODE_SREM]: begin
            if (cb == 64'd0) begin
               prep.line.fault = FAULT_DIVZ;
            end else if (sgn && slb == ALL_ONES &&
                         sla == (req.narrow ? 64'hFFFF_FFFF_8000_0000
                                            : 64'h8000_0000_0000_0000)) begin
               prep.line.fault = FAULT_DIVOVF;
            end else begin
               prep.line.kind = KIND_DIV;
            end
         end
         MODE_TOLE, MODE_TOBE: begin
            if (r == 64'd16) begin
               prep.line.res = (req.mode == MODE_TOBE) ? {48'd0, l[7:0], l[15:8]}
                                                       : {48'd0, l[15:0]};
            end else if (r == 64'd32) begin
               prep.line.res = (req.mode == MODE_TOBE)
                  ? {32'd0, l[7:0], l[15:8], l[23:16], l[31:24]}
                  : {32'd0, l[31:0]};
            end else if (r == 64'd64) begin
               prep.line.res = (req.mode == MODE_TOBE)
                  ? {l[7:0], l[15:8], l[23:16], l[31:24],
                     l[39:32], l[47:40], l[55:48], l[63:56]}
                  : l;
            end else begin
               prep.line.fault = FAULT_ENDIAN;
            end
         end
         MODE_HOR:
            prep.line.res = l | {r[31:0], 32'd0};
         MODE_JEQ:  prep.line.taken = eq;
         MODE_JNE:  prep.line.taken = !eq;
         MODE_JGT:  prep.line.taken = !ult && !eq;
         MODE_JGE:  prep.line.taken = !ult;
         MODE_JLT:  prep.line.taken = ult;
         MODE_JLE:  prep.line.taken = ult || eq;
         MODE_JSGT: prep.line.taken = !slt && !eq;
         MODE_JSGE: prep.line.taken = !slt;
         MODE_JSLT: prep.line.taken = slt;
         MODE_JSLE: prep.line.taken = slt || eq;
         MODE_JSET: prep.line.taken = ((ca & cb) != 64'd0);
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== src/bae_mul.sv =====
`default_nettype none
module bae_mul (
   input  logic        clock,
   input  logic [63:0] a,
   input  logic [63:0] b,
   input  logic        sgn,
   output logic [63:0] prod_lo,
   output logic [63:0] prod_hi
);
   import bae_pkg::*;

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [63:0]  a1_ff, b1_ff, a2_ff, b2_ff;
   logic         sgn1_ff, sgn2_ff;
   logic [127:0] sum_in, sum_ff;
   logic [63:0]  lo_ff, hi_ff, hi_in;

   // partial products
   always_ff @(posedge clock) begin
      ll_ff   <= a[31:0] * b[31:0];
      lh_ff   <= a[31:0] * b[63:32];
      hl_ff   <= a[63:32] * b[31:0];
      hh_ff   <= a[63:32] * b[63:32];
      a1_ff   <= a;
      b1_ff   <= b;
      sgn1_ff <= sgn;
   end

   assign sum_in = {64'd0, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
                 + {hh_ff, 64'd0};

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      a2_ff   <= a1_ff;
      b2_ff   <= b1_ff;
      sgn2_ff <= sgn1_ff;
   end

   // signed high word correction
   assign hi_in = sum_ff[127:64] - ((sgn2_ff && a2_ff[63]) ? b2_ff : 64'd0)
                                 - ((sgn2_ff && b2_ff[63]) ? a2_ff : 64'd0);

   always_ff @(posedge clock) begin
      lo_ff <= sum_ff[63:0];
      hi_ff <= hi_in;
   end

   assign prod_lo = lo_ff;
   assign prod_hi = hi_ff;

endmodule
`default_nettype wire

// ===== src/bae_div.sv =====
`default_nettype none
module bae_div (
   input  logic        clock,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);
   import bae_pkg::*;

   logic [63:0] rem_ff [0:DIV_DEPTH-1];
   logic [63:0] nq_ff  [0:DIV_DEPTH-1];
   logic [63:0] d_ff   [0:DIV_DEPTH-1];

   // one quotient bit per stage, restoring
   for (genvar j = 0; j < DIV_DEPTH; j++) begin : g_stage
      logic [63:0] rem_prev, nq_prev, d_prev, rem_in, nq_in;
      logic [64:0] trial, diff;
      if (j == 0) begin : g_first
         assign rem_prev = 64'd0;
         assign nq_prev  = dividend;
         assign d_prev   = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign nq_prev  = nq_ff[j-1];
         assign d_prev   = d_ff[j-1];
      end
      assign trial  = {rem_prev, nq_prev[63]};
      assign diff   = trial - {1'b0, d_prev};
      assign rem_in = diff[64] ? trial[63:0] : diff[63:0];
      assign nq_in  = {nq_prev[62:0], !diff[64]};
      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         nq_ff[j]  <= nq_in;
         d_ff[j]   <= d_prev;
      end
   end

   assign quotient  = nq_ff[DIV_DEPTH-1];
   assign remainder = rem_ff[DIV_DEPTH-1];

endmodule
`default_nettype wire
